### sv/clut_texture_texel_decode_unit_macros.svh
// Assertion macros shared by the texel decode unit modules.
// Each macro expects the enclosing module to have clk and arst_n.
`ifndef CLUT_TEXTURE_TEXEL_DECODE_UNIT_MACROS_SVH
`define CLUT_TEXTURE_TEXEL_DECODE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define CTTD_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("texel decode check failed");
`define CTTD_NEVER(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("texel decode forbidden condition seen");
`else
`define CTTD_ASSERT(label, prop)
`define CTTD_NEVER(label, expr)
`endif
`endif

### sv/cttd_pkg.sv
`default_nettype none
package cttd_pkg;

	// Configuration port.
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 2;
	localparam logic [CFG_INDEX_W-1:0] CFG_TEXTURE_MODE    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_PALETTE_PRESENT = 2'd1;

	// Texture modes; the fourth code behaves as direct colour.
	localparam logic [1:0] TEX_MODE_4BIT   = 2'd0;
	localparam logic [1:0] TEX_MODE_8BIT   = 2'd1;
	localparam logic [1:0] TEX_MODE_DIRECT = 2'd2;

	// Request kinds.
	localparam logic KIND_TEXEL = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	localparam int PAL_ENTRY_W = 32;
	localparam int INDEX_W     = 8;

	// Queue between front and back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_DIRECT = 2'd2,
		OP_ZERO   = 2'd3
	} op_t;

	// Colour is packed red in the low byte, then green, blue and alpha.
	typedef struct packed {
		op_t                    op;
		logic [INDEX_W-1:0]     index;
		logic [PAL_ENTRY_W-1:0] color;
	} entry_t;

	// Rounds an 8-bit channel to five bits as (v*31+127)/255. The division by
	// 255 uses the identity x/255 = (x + (x >> 8) + 1) >> 8, exact for x below 65535.
	function automatic logic [4:0] to_five(input logic [7:0] v);
		logic [12:0] x;
		logic [12:0] s;
		x = 13'(v) * 13'd31 + 13'd127;
		s = x + (x >> 8) + 13'd1;
		return s[12:8];
	endfunction

endpackage
`default_nettype wire

### sv/cttd_if.sv
`default_nettype none
interface cttd_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] slot;
	logic [7:0] src_red;
	logic [7:0] src_green;
	logic [7:0] src_blue;
	logic [7:0] src_alpha;
	logic [1:0] sub_position;

	modport source (output valid, kind, slot, src_red, src_green, src_blue, src_alpha,
		sub_position, input ready);
	modport sink (input valid, kind, slot, src_red, src_green, src_blue, src_alpha,
		sub_position, output ready);
endinterface

interface cttd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic [7:0] out_alpha;

	modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
	modport sink (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

interface cttd_cfg_if
	import cttd_pkg::*;
();
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### sv/cttd_ram.sv
`default_nettype none
module cttd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

### sv/cttd_queue.sv
`default_nettype none
`include "clut_texture_texel_decode_unit_macros.svh"
module cttd_queue
	import cttd_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire entry_t push_entry,
	output logic        full,
	output logic        head_valid,
	output entry_t      head_entry,
	input  wire logic   pop
);
	entry_t             slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`CTTD_NEVER(a_push_when_full, push && full)
	`CTTD_NEVER(a_pop_when_empty, pop && !head_valid)
	`CTTD_ASSERT(a_count_grows, (push && !pop) |=> count_q == $past(count_q) + 1'b1)
endmodule
`default_nettype wire

### sv/cttd_front.sv
`default_nettype none
module cttd_front
	import cttd_pkg::*;
#(
	parameter int PALETTE_ENTRIES = 256
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	cttd_in_if.sink    texel_in,
	cttd_cfg_if.sink   cfg,
	input  wire logic  q_full,
	output logic       push,
	output entry_t     push_entry
);
	logic [1:0]         mode_q;
	logic               present_q;
	logic [15:0]        word;
	logic [3:0]         nibble;
	logic [INDEX_W-1:0] idx;
	logic [PAL_ENTRY_W-1:0] src_color;
	logic               idx_in_range;
	logic               slot_in_range;
	logic               accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= TEX_MODE_4BIT;
			present_q <= 1'b1;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				CFG_TEXTURE_MODE:    mode_q    <= cfg.data[1:0];
				CFG_PALETTE_PRESENT: present_q <= cfg.data[0];
				default:             ;
			endcase
		end
	end

	assign cfg.ready      = 1'b1;
	assign texel_in.ready = !q_full;
	assign accept         = texel_in.valid && !q_full;

	assign src_color = {texel_in.src_alpha, texel_in.src_blue, texel_in.src_green,
		texel_in.src_red};

	// Rebuild the 15-bit colour word with the mask bit on top.
	assign word = {texel_in.src_alpha[7], to_five(texel_in.src_blue),
		to_five(texel_in.src_green), to_five(texel_in.src_red)};

	always_comb begin
		case (texel_in.sub_position)
			2'd0:    nibble = word[3:0];
			2'd1:    nibble = word[7:4];
			2'd2:    nibble = word[11:8];
			default: nibble = word[15:12];
		endcase
		if (mode_q == TEX_MODE_8BIT) begin
			idx = texel_in.sub_position[0] ? word[15:8] : word[7:0];
		end else begin
			idx = {4'b0, nibble};
		end
	end

	assign idx_in_range  = {1'b0, idx} < (INDEX_W + 1)'(PALETTE_ENTRIES);
	assign slot_in_range = {1'b0, texel_in.slot} < (INDEX_W + 1)'(PALETTE_ENTRIES);

	// Palette writes beyond the store are taken and dropped.
	assign push = accept && !(texel_in.kind == KIND_WRITE && !slot_in_range);

	always_comb begin
		push_entry.index = idx;
		push_entry.color = src_color;
		if (texel_in.kind == KIND_WRITE) begin
			push_entry.op    = OP_WRITE;
			push_entry.index = texel_in.slot;
		end else if (mode_q[1]) begin
			push_entry.op = OP_DIRECT;
		end else if (!present_q || !idx_in_range) begin
			push_entry.op    = OP_ZERO;
			push_entry.color = '0;
		end else begin
			push_entry.op = OP_LOOKUP;
		end
	end
endmodule
`default_nettype wire

### sv/cttd_back.sv
`default_nettype none
`include "clut_texture_texel_decode_unit_macros.svh"
module cttd_back
	import cttd_pkg::*;
#(
	parameter int PALETTE_ENTRIES = 256
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    head_valid,
	input  wire entry_t  head_entry,
	output logic         pop,
	cttd_out_if.source   texel_out
);
	localparam int AW = $clog2(PALETTE_ENTRIES);

	logic                   is_write;
	logic                   s1_free;
	logic                   out_free;
	logic                   ram_we;
	logic                   ram_re;
	logic [PAL_ENTRY_W-1:0] ram_rdata;
	logic                   v_s1;
	op_t                    op_s1;
	logic [PAL_ENTRY_W-1:0] color_s1;
	logic [PAL_ENTRY_W-1:0] src;
	logic                   out_valid_q;
	logic [7:0]             red_q;
	logic [7:0]             green_q;
	logic [7:0]             blue_q;
	logic [7:0]             alpha_q;

	assign is_write = (head_entry.op == OP_WRITE);
	assign out_free = !out_valid_q || texel_out.ready;
	assign s1_free  = !v_s1 || out_free;
	assign pop      = head_valid && (is_write || s1_free);
	assign ram_we   = pop && is_write;
	assign ram_re   = pop && (head_entry.op == OP_LOOKUP);

	// The read data register holds until the next lookup, so a stalled
	// lookup in stage one keeps its palette entry.
	cttd_ram #(
		.WIDTH (PAL_ENTRY_W),
		.DEPTH (PALETTE_ENTRIES)
	) u_palette (
		.clk   (clk),
		.we    (ram_we),
		.waddr (head_entry.index[AW-1:0]),
		.wdata (head_entry.color),
		.re    (ram_re),
		.raddr (head_entry.index[AW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_free) begin
			v_s1 <= pop && !is_write;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && pop && !is_write) begin
			op_s1    <= head_entry.op;
			color_s1 <= head_entry.color;
		end
	end

	assign src = (op_s1 == OP_LOOKUP) ? ram_rdata : color_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && v_s1) begin
			if (src == '0) begin
				red_q   <= '0;
				green_q <= '0;
				blue_q  <= '0;
				alpha_q <= '0;
			end else begin
				red_q   <= src[7:0];
				green_q <= src[15:8];
				blue_q  <= src[23:16];
				alpha_q <= 8'hff;
			end
		end
	end

	assign texel_out.valid     = out_valid_q;
	assign texel_out.out_red   = red_q;
	assign texel_out.out_green = green_q;
	assign texel_out.out_blue  = blue_q;
	assign texel_out.out_alpha = alpha_q;

	`CTTD_ASSERT(a_s1_holds, (v_s1 && !out_free) |=> (v_s1 && $stable(op_s1)))
	`CTTD_ASSERT(a_alpha_code, out_valid_q |-> (alpha_q == 8'h00 || alpha_q == 8'hff))
	`CTTD_ASSERT(a_clear_is_black, (out_valid_q && alpha_q == '0) |-> ({red_q, green_q, blue_q} == '0))
endmodule
`default_nettype wire

### sv/clut_texture_texel_decode_unit.sv
`default_nettype none
// Texel decoder for palette-indexed and direct-colour texture pages whose source
// words arrive as RGBA8. A request is either a palette write, which stores one
// RGBA8 entry and returns nothing, or a texel, which returns exactly one decoded
// colour. While the queue has room and the output is not stalled, the unit takes
// one request per clock and returns one result per clock. A texel result passes
// through the queue register, the registered palette read and the output
// register. The palette serves one write or one read per cycle in request
// order, so a texel always sees every palette write that was accepted before it.
// Requests keep flowing while a result waits at the output, until the queue fills:
// a four-deep queue separates the front, which converts and classifies, from the
// back, which owns the palette and the output register. The palette has no reset;
// reading an entry that was never written returns whatever the RAM holds. The
// texture mode and palette-present registers are written through the cfg channel,
// which is always ready, and must only change while the unit is idle.
module clut_texture_texel_decode_unit
	import cttd_pkg::*;
#(
	parameter int PALETTE_ENTRIES = 256
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	cttd_in_if.sink     texel_in,
	cttd_out_if.source  texel_out,
	cttd_cfg_if.sink    cfg
);
	// Front to queue.
	logic   push;
	entry_t push_entry;
	logic   q_full;

	// Queue to back.
	logic   head_valid;
	entry_t head_entry;
	logic   pop;

	// The front rounds each channel to five bits, cuts the palette index and decides
	// whether the back must write the palette, look up, pass through or return zero.
	cttd_front #(
		.PALETTE_ENTRIES (PALETTE_ENTRIES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.texel_in   (texel_in),
		.cfg        (cfg),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	cttd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop)
	);

	// The back applies palette writes, reads the palette for lookups and turns an
	// all-zero colour into transparent black, any other into opaque.
	cttd_back #(
		.PALETTE_ENTRIES (PALETTE_ENTRIES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop),
		.texel_out  (texel_out)
	);
endmodule
`default_nettype wire

### test/texel_colour_checker.sv
module texel_colour_checker
	import cttd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	cttd_in_if   texel_in,
	cttd_out_if  texel_out,
	cttd_cfg_if  cfg,
	output int   error_count,
	output int   pending_results
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PALETTE_SLOTS = 256;

	typedef struct packed {
		logic [7:0] alpha;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} rgba_t;

	rgba_t      palette_copy [PALETTE_SLOTS];
	logic [1:0] mode_reg;
	logic       present_reg;
	rgba_t      awaited_colours [$];
	int         mismatches;

	function automatic logic [4:0] round_to_five(input logic [7:0] v);
		int unsigned scaled;
		scaled = v * 31 + 127;
		return 5'(scaled / 255);
	endfunction

	// A colour of four zero bytes stays transparent; anything else becomes opaque.
	function automatic rgba_t opaque_or_clear(input rgba_t c);
		rgba_t shaded;
		shaded = c;
		if (c != '0) begin
			shaded.alpha = 8'hff;
		end
		return shaded;
	endfunction

	function automatic rgba_t decode_texel(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b, input logic [7:0] a, input logic [1:0] sub);
		logic [15:0] word;
		logic [7:0]  index;
		if (mode_reg >= TEX_MODE_DIRECT) begin
			return opaque_or_clear({a, b, g, r});
		end
		word = {a[7], round_to_five(b), round_to_five(g), round_to_five(r)};
		if (mode_reg == TEX_MODE_8BIT) begin
			index = sub[0] ? word[15:8] : word[7:0];
		end else begin
			index = 8'(word >> (4 * sub)) & 8'h0f;
		end
		if (!present_reg) begin
			return '0;
		end
		return opaque_or_clear(palette_copy[index]);
	endfunction

	function automatic bit colour_agrees(input rgba_t want, input rgba_t seen);
		bit ok;
		ok = 1'b1;
		if (want.red != seen.red) begin
			$error("out_red mismatch: expected %0d, got %0d", want.red, seen.red);
			ok = 1'b0;
		end
		if (want.green != seen.green) begin
			$error("out_green mismatch: expected %0d, got %0d", want.green, seen.green);
			ok = 1'b0;
		end
		if (want.blue != seen.blue) begin
			$error("out_blue mismatch: expected %0d, got %0d", want.blue, seen.blue);
			ok = 1'b0;
		end
		if (want.alpha != seen.alpha) begin
			$error("out_alpha mismatch: expected %0d, got %0d", want.alpha, seen.alpha);
			ok = 1'b0;
		end
		return ok;
	endfunction

	always @(posedge clk) begin : watch
		rgba_t seen;
		rgba_t want;
		if (!arst_n) begin
			mode_reg = TEX_MODE_4BIT;
			present_reg = 1'b1;
			awaited_colours.delete();
			mismatches = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_TEXTURE_MODE: begin
						mode_reg = cfg.data;
					end
					CFG_PALETTE_PRESENT: begin
						present_reg = cfg.data[0];
					end
					default: begin
					end
				endcase
			end
			if (texel_in.valid && texel_in.ready) begin
				if (texel_in.kind == KIND_WRITE) begin
					if (texel_in.slot < PALETTE_SLOTS) begin
						palette_copy[texel_in.slot] = {texel_in.src_alpha, texel_in.src_blue,
							texel_in.src_green, texel_in.src_red};
					end
				end else begin
					awaited_colours.push_back(decode_texel(texel_in.src_red, texel_in.src_green,
						texel_in.src_blue, texel_in.src_alpha, texel_in.sub_position));
				end
			end
			if (texel_out.valid && texel_out.ready) begin
				seen = {texel_out.out_alpha, texel_out.out_blue, texel_out.out_green,
					texel_out.out_red};
				if (awaited_colours.size() == 0) begin
					$error("unexpected result: nothing waiting, got %h", seen);
					mismatches++;
				end else begin
					want = awaited_colours.pop_front();
					if (!colour_agrees(want, seen)) begin
						mismatches++;
					end
				end
			end
		end
		error_count <= mismatches;
		pending_results <= awaited_colours.size();
	end

endmodule

### test/testbench.sv
module testbench;
	import cttd_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// The fourth texture mode code has no name in the package; it decodes as direct colour.
	localparam logic [1:0] TEX_MODE_SPARE = 2'd3;

	// Cycles allowed after the last result before a register write, since palette
	// write requests return nothing and may still be in flight.
	localparam int SETTLE_CYCLES  = 8;
	localparam int DRAIN_CYCLES   = 20;
	localparam int LONG_HOLD      = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int BUSY_PCT       = 78;
	localparam int LIGHT_PCT      = 12;

	typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_style_t;

	logic clk;
	logic arst_n;
	int   tx_idle_pct;
	int   rx_stall_pct;
	int   hold_requests;
	int   quiet_cycles = 0;
	int   error_count;
	int   pending_results;

	cttd_in_if  texel_in ();
	cttd_out_if texel_out ();
	cttd_cfg_if cfg_bus ();

	clut_texture_texel_decode_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.texel_in (texel_in),
		.texel_out(texel_out),
		.cfg      (cfg_bus)
	);

	texel_colour_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.texel_in       (texel_in),
		.texel_out      (texel_out),
		.cfg            (cfg_bus),
		.error_count    (error_count),
		.pending_results(pending_results)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// The result side. It normally stalls at random at the rate the current phase
	// sets, but whenever the stimulus asks for a long hold it keeps ready low until
	// its own LONG_HOLD countdown runs out, so that the unit's internal queue fills
	// and back-pressure reaches the request side.
	initial begin : result_sink
		int hold_left;
		int holds_served;
		hold_left = 0;
		holds_served = 0;
		texel_out.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requests != holds_served) begin
				holds_served = hold_requests;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				texel_out.ready <= 1'b0;
			end else begin
				texel_out.ready <= !(rx_stall_pct != 0 && $urandom_range(1, 100) <= rx_stall_pct);
			end
		end
	end

	// Watchdog: any accepted request, result or register write counts as progress.
	always @(posedge clk) begin
		if (!arst_n || (texel_in.valid && texel_in.ready) || (texel_out.valid && texel_out.ready)
			|| (cfg_bus.valid && cfg_bus.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Offers one request and returns at the edge where it is taken. Valid is left
	// high so that back-to-back requests follow without a gap; idle cycles, when the
	// phase asks for them, are put in front of the request.
	task automatic offer(input logic kind, input logic [7:0] slot, input logic [7:0] r,
		input logic [7:0] g, input logic [7:0] b, input logic [7:0] a, input logic [1:0] sub);
		while (tx_idle_pct != 0 && $urandom_range(1, 100) <= tx_idle_pct) begin
			texel_in.valid <= 1'b0;
			@(posedge clk);
		end
		texel_in.valid        <= 1'b1;
		texel_in.kind         <= kind;
		texel_in.slot         <= slot;
		texel_in.src_red      <= r;
		texel_in.src_green    <= g;
		texel_in.src_blue     <= b;
		texel_in.src_alpha    <= a;
		texel_in.sub_position <= sub;
		do @(posedge clk); while (!texel_in.ready);
	endtask

	// Stops offering requests and waits until every decoded texel has come back.
	task automatic wait_for_results();
		texel_in.valid <= 1'b0;
		do @(posedge clk); while (pending_results != 0);
	endtask

	// Both registers are written back to back, and only once the unit is idle.
	task automatic apply_config(input logic [1:0] mode, input logic present);
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= CFG_TEXTURE_MODE;
		cfg_bus.data  <= mode;
		do @(posedge clk); while (!cfg_bus.ready);
		cfg_bus.index <= CFG_PALETTE_PRESENT;
		cfg_bus.data  <= {1'b0, present};
		do @(posedge clk); while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
	endtask

	// Channel bytes lean towards the extremes and the middle, where the rounding
	// to five bits and the mask bit change.
	function automatic logic [7:0] rand_channel();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hff;
			2: return 8'($urandom_range(120, 135));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Mostly texel requests, with palette writes mixed in. In four-bit mode at least half
	// of the writes land in the sixteen reachable slots, so a texel often reads an
	// entry that was rewritten only a few requests earlier.
	task automatic offer_random(input logic [1:0] mode);
		logic [7:0] slot;
		if ($urandom_range(0, 99) < 15) begin
			if (mode == TEX_MODE_4BIT && $urandom_range(0, 1) == 1) begin
				slot = 8'($urandom_range(0, 15));
			end else begin
				slot = 8'($urandom_range(0, 255));
			end
			if ($urandom_range(0, 9) == 0) begin
				offer(KIND_WRITE, slot, 8'h00, 8'h00, 8'h00, 8'h00, 2'($urandom_range(0, 3)));
			end else begin
				offer(KIND_WRITE, slot, rand_channel(), rand_channel(), rand_channel(),
					rand_channel(), 2'($urandom_range(0, 3)));
			end
		end else begin
			offer(KIND_TEXEL, 8'($urandom_range(0, 255)), rand_channel(), rand_channel(),
				rand_channel(), rand_channel(), 2'($urandom_range(0, 3)));
		end
	endtask

	// One phase of random requests under one register setting and one idling style.
	// With pressure set, the result side is told to hold off for a long stretch
	// halfway through while requests keep coming without gaps; afterwards the
	// request side pauses until every texel has been returned.
	task automatic run_phase(input logic [1:0] mode, input logic present,
		input idle_style_t style, input int count, input bit pressure);
		int saved_idle;
		saved_idle = 0;
		apply_config(mode, present);
		tx_idle_pct = (style == IDLE_SENDER) ? BUSY_PCT : (style == IDLE_BOTH) ? LIGHT_PCT : 0;
		rx_stall_pct <= (style == IDLE_RECEIVER) ? BUSY_PCT : (style == IDLE_BOTH) ? LIGHT_PCT : 0;
		for (int i = 0; i < count; i++) begin
			if (pressure && i == count / 2) begin
				hold_requests <= hold_requests + 1;
				saved_idle = tx_idle_pct;
				tx_idle_pct = 0;
			end
			if (pressure && i == count / 2 + 40) begin
				tx_idle_pct = saved_idle;
				wait_for_results();
			end
			offer_random(mode);
		end
	endtask

	initial begin : stimulus
		int order [256];
		int j;
		int tmp;

		arst_n                <= 1'b0;
		texel_in.valid        <= 1'b0;
		texel_in.kind         <= KIND_TEXEL;
		texel_in.slot         <= 8'h00;
		texel_in.src_red      <= 8'h00;
		texel_in.src_green    <= 8'h00;
		texel_in.src_blue     <= 8'h00;
		texel_in.src_alpha    <= 8'h00;
		texel_in.sub_position <= 2'd0;
		cfg_bus.valid         <= 1'b0;
		cfg_bus.index         <= CFG_TEXTURE_MODE;
		cfg_bus.data          <= TEX_MODE_4BIT;
		tx_idle_pct = 0;
		rx_stall_pct  <= 0;
		hold_requests <= 0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. The palette has no reset, so only the three slots written
		// here are read: an all-zero colour maps to index zero in both indexed modes and
		// a fully saturated one to fifteen in four-bit mode and 255 in eight-bit mode.
		apply_config(TEX_MODE_4BIT, 1'b1);
		offer(KIND_WRITE, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, 2'd0);
		offer(KIND_WRITE, 8'd15, 8'hff, 8'h00, 8'h80, 8'h01, 2'd3);
		offer(KIND_WRITE, 8'd255, 8'h12, 8'h34, 8'h56, 8'h00, 2'd1);
		// An entry of four zero bytes comes back as transparent black.
		offer(KIND_TEXEL, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, 2'd0);
		for (int s = 0; s < 4; s++) begin
			offer(KIND_TEXEL, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 2'(s));
		end

		// Eight-bit mode: only bit zero of the sub-position picks the byte.
		apply_config(TEX_MODE_8BIT, 1'b1);
		offer(KIND_TEXEL, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, 2'd1);
		offer(KIND_TEXEL, 8'd0, 8'hff, 8'hff, 8'hff, 8'hff, 2'd0);
		offer(KIND_TEXEL, 8'd0, 8'hff, 8'hff, 8'hff, 8'hff, 2'd3);

		// Direct colour: the pixel passes through, with alpha forced to 255 unless
		// all four bytes are zero.
		apply_config(TEX_MODE_DIRECT, 1'b1);
		offer(KIND_TEXEL, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, 2'd0);
		offer(KIND_TEXEL, 8'd0, 8'hff, 8'hff, 8'hff, 8'hff, 2'd2);
		offer(KIND_TEXEL, 8'd0, 8'h01, 8'h00, 8'h00, 8'h00, 2'd1);
		offer(KIND_TEXEL, 8'd0, 8'h00, 8'h00, 8'h00, 8'h80, 2'd3);

		// The spare mode code behaves as direct colour.
		apply_config(TEX_MODE_SPARE, 1'b1);
		offer(KIND_TEXEL, 8'd0, 8'h00, 8'h00, 8'h00, 8'h01, 2'd0);
		offer(KIND_TEXEL, 8'd0, 8'h09, 8'h08, 8'h07, 8'h06, 2'd2);

		// Without a palette every indexed texel decodes to zero.
		apply_config(TEX_MODE_4BIT, 1'b0);
		offer(KIND_TEXEL, 8'd0, 8'hff, 8'hff, 8'hff, 8'hff, 2'd0);
		offer(KIND_TEXEL, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, 2'd2);

		// Fill the whole palette in a shuffled order before any random texel can
		// reach an arbitrary index. Some entries are left as all-zero colours.
		for (int i = 0; i < 256; i++) begin
			order[i] = i;
		end
		for (int i = 255; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		for (int i = 0; i < 256; i++) begin
			if ($urandom_range(0, 7) == 0) begin
				offer(KIND_WRITE, 8'(order[i]), 8'h00, 8'h00, 8'h00, 8'h00, 2'($urandom_range(0, 3)));
			end else begin
				offer(KIND_WRITE, 8'(order[i]), rand_channel(), rand_channel(), rand_channel(),
					rand_channel(), 2'($urandom_range(0, 3)));
			end
		end

		// Random phases, walking through every texture mode code and every idling style.
		run_phase(TEX_MODE_4BIT, 1'b1, IDLE_NONE, 150, 1'b0);
		run_phase(TEX_MODE_8BIT, 1'b1, IDLE_SENDER, 150, 1'b0);
		run_phase(TEX_MODE_4BIT, 1'b1, IDLE_RECEIVER, 150, 1'b1);
		run_phase(TEX_MODE_8BIT, 1'b1, IDLE_BOTH, 150, 1'b0);
		run_phase(TEX_MODE_DIRECT, 1'b1, IDLE_NONE, 150, 1'b0);
		run_phase(TEX_MODE_SPARE, 1'b0, IDLE_RECEIVER, 150, 1'b0);
		run_phase(TEX_MODE_4BIT, 1'b0, IDLE_SENDER, 150, 1'b0);
		run_phase(TEX_MODE_8BIT, 1'b0, IDLE_BOTH, 150, 1'b0);
		run_phase(TEX_MODE_8BIT, 1'b1, IDLE_RECEIVER, 150, 1'b1);
		run_phase(TEX_MODE_4BIT, 1'b1, IDLE_BOTH, 150, 1'b0);

		// Let the last results arrive, then give any stray result time to show up.
		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_results == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

### sim.f
+incdir+sv
sv/cttd_pkg.sv
sv/cttd_if.sv
sv/cttd_ram.sv
sv/cttd_queue.sv
sv/cttd_front.sv
sv/cttd_back.sv
sv/clut_texture_texel_decode_unit.sv
test/texel_colour_checker.sv
test/testbench.sv
